// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Needs a clk and an rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check on every clock edge outside reset.
`define CJS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define CJS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/cjs_pkg.sv
// Package of the contact Jacobian setup block: formats, item types, register
// indexes and the fixed-point helper functions. No dependencies.
package cjs_pkg;

    // Number formats
    localparam int VEC_W      = 21;
    localparam int SCAL_W     = 32;
    localparam int VEC_FRAC   = 12;
    localparam int SCAL_FRAC  = 16;
    localparam int PACK_W     = 3 * VEC_W;

    // Widths of the cross-product datapath
    localparam int R_W  = VEC_W + 1;
    localparam int P_W  = R_W + VEC_W;
    localparam int X_W  = P_W + 1;
    localparam int N_W  = X_W + 1;
    localparam int T_W  = N_W + 1;
    localparam int SH_W = T_W - VEC_FRAC;

    // Divider: one quotient bit per stage
    localparam int DIV_W      = 48;
    localparam int DEN_W      = 32;
    localparam int DIV_STAGES = DIV_W;

    // Register indexes and reset values
    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_BAUMGARTE = 2'd1;
    localparam logic [1:0] CFG_SLOP      = 2'd2;
    localparam logic [30:0] TIME_STEP_RST = 31'd1092;
    localparam logic [15:0] BAUMGARTE_RST = 16'd13107;
    localparam logic [30:0] SLOP_RST      = 31'd328;

    // Scalar bounds
    localparam logic signed [47:0] S_HI = (48'sd1 <<< (SCAL_W - 1)) - 48'sd1;
    localparam logic signed [47:0] S_LO = -S_HI - 48'sd1;
    localparam logic [31:0] S_MAX32 = 32'(S_HI);
    localparam logic [31:0] S_MIN32 = 32'(S_LO);
    localparam logic [DIV_W-1:0] Q_NEG_LIMIT = DIV_W'(48'sd1 <<< (SCAL_W - 1));
    localparam logic [DIV_W-1:0] Q_MASS_LIMIT = DIV_W'(S_HI);
    localparam logic signed [47:0] FREE_LIMIT = 48'sd1000 <<< SCAL_FRAC;

    typedef struct packed {
        logic              req_type;
        logic [62:0]       contact_pos;
        logic [62:0]       pos_a;
        logic [62:0]       pos_b;
        logic [62:0]       direction;
        logic [30:0]       inv_mass_a;
        logic [30:0]       inv_mass_b;
        logic signed [31:0] penetration;
        logic signed [31:0] normal_lambda;
        logic [30:0]       fric_mu;
        logic              has_normal_limit;
        logic              bodies_present;
    } in_item_t;

    typedef struct packed {
        logic [62:0]       linear_row_b;
        logic [62:0]       angular_row_a;
        logic [62:0]       angular_row_b;
        logic [30:0]       effective_mass;
        logic signed [31:0] bias_term;
        logic signed [31:0] min_limit;
        logic signed [31:0] max_limit;
        logic              skipped;
    } out_item_t;

    // Classified row handed from the front to the divider back end
    typedef struct packed {
        logic [62:0]      linear_row_b;
        logic [62:0]      angular_row_a;
        logic [62:0]      angular_row_b;
        logic [31:0]      min_limit;
        logic [31:0]      max_limit;
        logic             skipped;
        logic [DIV_W-1:0] bias_num;
        logic             bias_pos;
        logic [DIV_W-1:0] mass_num;
        logic [DEN_W-1:0] mass_den;
        logic             mass_zero;
    } row_t;

    function automatic logic signed [VEC_W-1:0] vec_comp(input logic [62:0] v,
                                                        input int i);
        return $signed(v[i*VEC_W +: VEC_W]);
    endfunction

    function automatic logic [VEC_W-1:0] sat_vec(input logic signed [SH_W-1:0] v);
        logic signed [SH_W-1:0] hi;
        logic signed [SH_W-1:0] lo;
        hi = (SH_W'(1) <<< (VEC_W - 1)) - SH_W'(1);
        lo = -hi - SH_W'(1);
        if (v > hi)
            return VEC_W'(hi);
        else if (v < lo)
            return VEC_W'(lo);
        else
            return VEC_W'(v);
    endfunction

    // Round to nearest (ties up) from Q.24 to Q.12, then saturate
    function automatic logic [VEC_W-1:0] round_vec(input logic signed [N_W-1:0] v);
        logic signed [T_W-1:0] t;
        t = T_W'(v) + T_W'(1 << (VEC_FRAC - 1));
        return sat_vec($signed(t[T_W-1:VEC_FRAC]));
    endfunction

    function automatic logic [31:0] sat_scal(input logic signed [47:0] v);
        if (v > S_HI)
            return S_MAX32;
        else if (v < S_LO)
            return S_MIN32;
        else
            return 32'(v);
    endfunction

    // One restoring division step: {quotient bit, next remainder}
    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                                input logic [DEN_W-1:0] den,
                                                input logic nb);
        logic [DEN_W:0] t;
        t = {rem, nb};
        if (t >= {1'b0, den})
            return {1'b1, DEN_W'(t - {1'b0, den})};
        else
            return {1'b0, t[DEN_W-1:0]};
    endfunction

endpackage

// File: rtl/cjs_if.sv
// Handshake channels of the contact Jacobian setup block.
// Depends on cjs_pkg for the item types.
interface cjs_in_if;
    import cjs_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cjs_out_if;
    import cjs_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/contact_jacobian_setup.sv
// Contact Jacobian setup: one item in and one result out per clock when the
// output is taken; a result passes through three front stages, the queue, one
// divider stage per quotient bit for 48 bits and the output register.
// The 48-stage divider pipeline is the longest part; throughput is one item/cycle.
// rst_n clears all valid state and loads the register defaults; no clearing
// pass is needed.
module contact_jacobian_setup (
    input  logic        clk,
    input  logic        rst_n,
    cjs_in_if.sink      in_ch,
    cjs_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    import cjs_pkg::*;

    logic [30:0]   time_step_reg;
    logic [15:0]   baumgarte_reg;
    logic [30:0]   slop_reg;
    logic          q_push_valid;
    logic          q_push_ready;
    row_t          q_push_data;
    logic          q_pop_valid;
    logic          q_pop_ready;
    row_t          q_pop_data;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RST;
            baumgarte_reg <= BAUMGARTE_RST;
            slop_reg      <= SLOP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIME_STEP: time_step_reg <= cfg_data;
                CFG_BAUMGARTE: baumgarte_reg <= cfg_data[15:0];
                CFG_SLOP:      slop_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    cjs_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .time_step        (time_step_reg),
        .baumgarte_factor (baumgarte_reg),
        .penetration_slop (slop_reg),
        .in_ch            (in_ch),
        .row_valid        (q_push_valid),
        .row_data         (q_push_data),
        .row_ready        (q_push_ready)
    );

    cjs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    cjs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .time_step (time_step_reg),
        .row_valid (q_pop_valid),
        .row_ready (q_pop_ready),
        .row_data  (q_pop_data),
        .out_ch    (out_ch)
    );

endmodule

// File: rtl/cjs_front.sv
// Front end: accepts items, forms lever arms, cross products, limits and
// divider operands over three stages. Depends on cjs_pkg and cjs_if.
module cjs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [30:0]       time_step,
    input  logic [15:0]       baumgarte_factor,
    input  logic [30:0]       penetration_slop,
    cjs_in_if.sink            in_ch,
    output logic              row_valid,
    output cjs_pkg::row_t     row_data,
    input  logic              row_ready
);
    import cjs_pkg::*;

    logic adv;

    // Stage 1 registers
    logic                     f1_valid_reg;
    logic signed [R_W-1:0]    f1_ra_reg [3];
    logic signed [R_W-1:0]    f1_rb_reg [3];
    logic signed [VEC_W-1:0]  f1_d_reg [3];
    logic [62:0]              f1_lin_reg;
    logic [DEN_W-1:0]         f1_sum_reg;
    logic signed [32:0]       f1_diff_reg;
    logic [30:0]              f1_mu_reg;
    logic signed [31:0]       f1_lam_reg;
    logic                     f1_fric_reg;
    logic                     f1_link_reg;
    logic                     f1_skip_reg;

    // Stage 2 registers
    logic                     f2_valid_reg;
    logic signed [P_W-1:0]    f2_pa_reg [3][2];
    logic signed [P_W-1:0]    f2_pb_reg [3][2];
    logic [62:0]              f2_lin_reg;
    logic [DEN_W-1:0]         f2_sum_reg;
    logic [DIV_W-1:0]         f2_bnum_reg;
    logic signed [62:0]       f2_mprod_reg;
    logic                     f2_fric_reg;
    logic                     f2_link_reg;
    logic                     f2_skip_reg;

    // Stage 3 register
    logic                     f3_valid_reg;
    row_t                     f3_row_reg;
    row_t                     f3_row_next;

    // Advance all stages together unless the last one is held
    assign adv         = !f3_valid_reg || row_ready;
    assign in_ch.ready = adv;
    assign row_valid   = f3_valid_reg;
    assign row_data    = f3_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= in_ch.valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    // Stage 1: lever arms, mass sum, penetration excess
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                f1_ra_reg[i] <= R_W'(vec_comp(in_ch.data.contact_pos, i))
                              - R_W'(vec_comp(in_ch.data.pos_a, i));
                f1_rb_reg[i] <= R_W'(vec_comp(in_ch.data.contact_pos, i))
                              - R_W'(vec_comp(in_ch.data.pos_b, i));
                f1_d_reg[i]  <= vec_comp(in_ch.data.direction, i);
            end
            f1_lin_reg  <= 63'(in_ch.data.direction[PACK_W-1:0]);
            f1_sum_reg  <= DEN_W'(in_ch.data.inv_mass_a) + DEN_W'(in_ch.data.inv_mass_b);
            f1_diff_reg <= 33'(in_ch.data.penetration) - $signed({2'b00, penetration_slop});
            f1_mu_reg   <= in_ch.data.fric_mu;
            f1_lam_reg  <= in_ch.data.normal_lambda;
            f1_fric_reg <= in_ch.data.req_type;
            f1_link_reg <= in_ch.data.has_normal_limit;
            f1_skip_reg <= !in_ch.data.req_type && !in_ch.data.bodies_present;
        end
    end

    // Stage 2: partial products of the cross products, bias and limit products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                f2_pa_reg[i][0] <= f1_ra_reg[(i + 1) % 3] * f1_d_reg[(i + 2) % 3];
                f2_pa_reg[i][1] <= f1_ra_reg[(i + 2) % 3] * f1_d_reg[(i + 1) % 3];
                f2_pb_reg[i][0] <= f1_rb_reg[(i + 1) % 3] * f1_d_reg[(i + 2) % 3];
                f2_pb_reg[i][1] <= f1_rb_reg[(i + 2) % 3] * f1_d_reg[(i + 1) % 3];
            end
            f2_lin_reg   <= f1_lin_reg;
            f2_sum_reg   <= f1_sum_reg;
            if (f1_diff_reg > 33'sd0)
                f2_bnum_reg <= DIV_W'(baumgarte_factor) * DIV_W'(f1_diff_reg[31:0]);
            else
                f2_bnum_reg <= '0;
            f2_mprod_reg <= $signed({1'b0, f1_mu_reg}) * f1_lam_reg;
            f2_fric_reg  <= f1_fric_reg;
            f2_link_reg  <= f1_link_reg;
            f2_skip_reg  <= f1_skip_reg;
        end
    end

    // Stage 3: round and saturate, pick limits, set up divider operands
    always_comb
    begin
        logic signed [X_W-1:0] xa;
        logic signed [X_W-1:0] xb;
        logic signed [63:0]    lt;
        logic signed [47:0]    lim;
        f3_row_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            xa = X_W'(f2_pa_reg[i][0]) - X_W'(f2_pa_reg[i][1]);
            xb = X_W'(f2_pb_reg[i][0]) - X_W'(f2_pb_reg[i][1]);
            f3_row_next.angular_row_a[i*VEC_W +: VEC_W] = round_vec(-N_W'(xa));
            f3_row_next.angular_row_b[i*VEC_W +: VEC_W] = round_vec(N_W'(xb));
        end
        lt  = 64'(f2_mprod_reg) + 64'sd32768;
        lim = 48'(lt >>> SCAL_FRAC);
        f3_row_next.linear_row_b = f2_lin_reg;
        priority if (!f2_fric_reg)
        begin
            f3_row_next.min_limit = '0;
            f3_row_next.max_limit = S_MAX32;
            f3_row_next.bias_num  = f2_bnum_reg + DIV_W'(time_step >> 1);
            f3_row_next.bias_pos  = (f2_bnum_reg != '0);
        end
        else if (f2_link_reg)
        begin
            f3_row_next.min_limit = sat_scal(-lim);
            f3_row_next.max_limit = sat_scal(lim);
        end
        else
        begin
            f3_row_next.min_limit = sat_scal(-FREE_LIMIT);
            f3_row_next.max_limit = sat_scal(FREE_LIMIT);
        end
        f3_row_next.mass_num  = DIV_W'(64'd1 << 32) + DIV_W'(f2_sum_reg >> 1);
        f3_row_next.mass_den  = f2_sum_reg;
        f3_row_next.mass_zero = (f2_sum_reg == '0);
        // Drop everything for a normal row with a missing body
        if (f2_skip_reg)
        begin
            f3_row_next           = '0;
            f3_row_next.skipped   = 1'b1;
            f3_row_next.mass_zero = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            f3_row_reg <= f3_row_next;
    end

endmodule

// File: rtl/cjs_queue.sv
// Two-entry queue between the front end and the divider back end.
// Depends on cjs_pkg for the row type.
module cjs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  cjs_pkg::row_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output cjs_pkg::row_t pop_data
);
    import cjs_pkg::*;

    row_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // Store an item
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/cjs_back.sv
// Back end: pipelined restoring dividers for bias and effective mass, one
// quotient bit per stage, and the output register. Depends on cjs_pkg, cjs_if.
module cjs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [30:0]   time_step,
    input  logic          row_valid,
    output logic          row_ready,
    input  cjs_pkg::row_t row_data,
    cjs_out_if.source     out_ch
);
    import cjs_pkg::*;

    logic                   adv;
    logic [DIV_STAGES:1]    st_valid_reg;
    row_t                   st_row_reg [1:DIV_STAGES];
    logic [DIV_W-1:0]       st_bnq_reg [1:DIV_STAGES];
    logic [DEN_W-1:0]       st_brem_reg [1:DIV_STAGES];
    logic [DIV_W-1:0]       st_mnq_reg [1:DIV_STAGES];
    logic [DEN_W-1:0]       st_mrem_reg [1:DIV_STAGES];
    logic [DEN_W-1:0]       bias_den;
    logic                   out_valid_reg;
    out_item_t              out_reg;
    out_item_t              out_next;

    assign adv          = !out_valid_reg || out_ch.ready;
    assign row_ready    = adv;
    assign bias_den     = {1'b0, time_step};
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // Shift valid bits along the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            st_valid_reg  <= {st_valid_reg[DIV_STAGES-1:1], row_valid};
            out_valid_reg <= st_valid_reg[DIV_STAGES];
        end
    end

    // One quotient bit of each divider per stage
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        row_t             src_row;
        logic [DIV_W-1:0] src_bnq;
        logic [DEN_W-1:0] src_brem;
        logic [DIV_W-1:0] src_mnq;
        logic [DEN_W-1:0] src_mrem;
        logic [DEN_W:0]   bstep;
        logic [DEN_W:0]   mstep;

        if (s == 0)
        begin : g_first
            assign src_row  = row_data;
            assign src_bnq  = row_data.bias_num;
            assign src_brem = '0;
            assign src_mnq  = row_data.mass_num;
            assign src_mrem = '0;
        end
        else
        begin : g_next
            assign src_row  = st_row_reg[s];
            assign src_bnq  = st_bnq_reg[s];
            assign src_brem = st_brem_reg[s];
            assign src_mnq  = st_mnq_reg[s];
            assign src_mrem = st_mrem_reg[s];
        end

        assign bstep = div_step(src_brem, bias_den, src_bnq[DIV_W-1]);
        assign mstep = div_step(src_mrem, src_row.mass_den, src_mnq[DIV_W-1]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_row_reg[s+1]  <= src_row;
                st_bnq_reg[s+1]  <= {src_bnq[DIV_W-2:0], bstep[DEN_W]};
                st_brem_reg[s+1] <= bstep[DEN_W-1:0];
                st_mnq_reg[s+1]  <= {src_mnq[DIV_W-2:0], mstep[DEN_W]};
                st_mrem_reg[s+1] <= mstep[DEN_W-1:0];
            end
        end
    end

    // Saturate quotients and assemble the result item
    always_comb
    begin
        row_t             r;
        logic [DIV_W-1:0] qb;
        logic [DIV_W-1:0] qm;
        r  = st_row_reg[DIV_STAGES];
        qb = st_bnq_reg[DIV_STAGES];
        qm = st_mnq_reg[DIV_STAGES];
        out_next.linear_row_b  = r.linear_row_b;
        out_next.angular_row_a = r.angular_row_a;
        out_next.angular_row_b = r.angular_row_b;
        out_next.min_limit     = r.min_limit;
        out_next.max_limit     = r.max_limit;
        out_next.skipped       = r.skipped;
        priority if (time_step == '0)
            out_next.bias_term = r.bias_pos ? S_MIN32 : '0;
        else if (qb > Q_NEG_LIMIT)
            out_next.bias_term = S_MIN32;
        else
            out_next.bias_term = 32'(DIV_W'(0) - qb);
        priority if (r.mass_zero)
            out_next.effective_mass = '0;
        else if (qm > Q_MASS_LIMIT)
            out_next.effective_mass = 31'(Q_MASS_LIMIT);
        else
            out_next.effective_mass = qm[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

endmodule

// File: rtl/cjs_checker.sv
// Port-level checks of the contact Jacobian setup result channel, bound to
// the top level. Depends on cjs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cjs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input cjs_pkg::out_item_t  out_data
);
    import cjs_pkg::*;

    // Hold a stalled result
    `CJS_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled item changed")
    // A skipped row has zero mass, bias, upper limit and angular row a
    `CJS_ASSERT(a_skip_zero, out_valid && out_data.skipped |-> out_data.effective_mass == '0 && out_data.bias_term == '0 && out_data.max_limit == '0 && out_data.angular_row_a == '0, "skipped item not cleared")
    // Bias only on normal rows, which use the fixed limits
    `CJS_ASSERT(a_bias_limits, out_valid && out_data.bias_term != '0 |-> out_data.min_limit == '0 && out_data.max_limit == S_MAX32, "bias on a row without normal limits")
    // Bias never pushes into the contact
    `CJS_ASSERT(a_bias_sign, out_valid |-> out_data.bias_term <= 32'sd0, "positive bias")
    // No result right after reset
    `CJS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid out of reset")

endmodule

bind contact_jacobian_setup cjs_checker u_cjs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

// File: tb/contact_jacobian_setup_test.sv
// Self-checking bench for contact_jacobian_setup: directed and random contact rows,
// with a bit-exact row predictor, register changes between phases and random stalls.
// Depends on cjs_pkg, cjs_if.sv and the RTL of the block.
module contact_jacobian_setup_test;
    import cjs_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [30:0] cfg_data;

    cjs_in_if in_ch ();
    cjs_out_if out_ch ();

    contact_jacobian_setup dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor copy of the registers
    logic [30:0] dt_reg;
    logic [15:0] beta_reg;
    logic [30:0] slop_reg;

    function automatic longint comp(input logic [62:0] v, input int i);
        logic signed [20:0] c;
        c = v[i*21 +: 21];
        return longint'(c);
    endfunction

    function automatic longint sat_to(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // Round to nearest, ties up, by s bits (arithmetic shift is a floor)
    function automatic longint round_down_by(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [62:0] lever_cross(input logic [62:0] cp, input logic [62:0] p,
                                                input logic [62:0] d, input bit neg);
        longint r[3];
        longint dv[3];
        longint x[3];
        longint o;
        logic [62:0] res;
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            r[i] = comp(cp, i) - comp(p, i);
            dv[i] = comp(d, i);
        end
        x[0] = r[1] * dv[2] - r[2] * dv[1];
        x[1] = r[2] * dv[0] - r[0] * dv[2];
        x[2] = r[0] * dv[1] - r[1] * dv[0];
        for (int i = 0; i < 3; i++)
        begin
            o = sat_to(round_down_by(neg ? -x[i] : x[i], VEC_FRAC), VEC_W);
            res[i*21 +: 21] = o[20:0];
        end
        return res;
    endfunction

    function automatic out_item_t predict_row(input in_item_t it);
        out_item_t r;
        longint smax;
        longint sum;
        longint q;
        longint pen;
        longint num;
        longint lim;
        longint lo;
        longint hi;
        longint bias;
        smax = 64'h7fff_ffff;
        r = '0;
        if (!it.req_type && !it.bodies_present)
        begin
            r.skipped = 1'b1;
            return r;
        end
        sum = longint'(it.inv_mass_a) + longint'(it.inv_mass_b);
        if (sum != 0)
        begin
            q = ((longint'(1) <<< 32) + sum / 2) / sum;
            r.effective_mass = 31'(q > smax ? smax : q);
        end
        bias = 0;
        if (!it.req_type)
        begin
            pen = longint'(it.penetration);
            if (pen > longint'(slop_reg))
            begin
                num = longint'(beta_reg) * (pen - longint'(slop_reg));
                if (dt_reg == 0)
                    bias = num > 0 ? -smax - 1 : 0;
                else
                    bias = sat_to(-((num + longint'(dt_reg) / 2) / longint'(dt_reg)), 32);
            end
            lo = 0;
            hi = smax;
        end
        else if (it.has_normal_limit)
        begin
            lim = round_down_by(longint'(it.fric_mu) * longint'(it.normal_lambda),
                                SCAL_FRAC);
            hi = sat_to(lim, 32);
            lo = sat_to(-lim, 32);
        end
        else
        begin
            hi = 1000 * 65536;
            lo = -1000 * 65536;
        end
        r.linear_row_b = it.direction;
        r.angular_row_a = lever_cross(it.contact_pos, it.pos_a, it.direction, 1'b1);
        r.angular_row_b = lever_cross(it.contact_pos, it.pos_b, it.direction, 1'b0);
        r.bias_term = bias[31:0];
        r.min_limit = lo[31:0];
        r.max_limit = hi[31:0];
        return r;
    endfunction

    class row_scoreboard;
        out_item_t pending[$];
        int errors;
        int checked;

        // Note an accepted item by its predicted result
        function void note_row(input in_item_t it);
            pending.push_back(predict_row(it));
        endfunction

        function void check_row(input out_item_t got);
            out_item_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected row, actual %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.linear_row_b !== e.linear_row_b)
                report("linear_row_b", e.linear_row_b, got.linear_row_b);
            if (got.angular_row_a !== e.angular_row_a)
                report("angular_row_a", e.angular_row_a, got.angular_row_a);
            if (got.angular_row_b !== e.angular_row_b)
                report("angular_row_b", e.angular_row_b, got.angular_row_b);
            if (got.effective_mass !== e.effective_mass)
                report("effective_mass", e.effective_mass, got.effective_mass);
            if (got.bias_term !== e.bias_term)
                report("bias_term", e.bias_term, got.bias_term);
            if (got.min_limit !== e.min_limit)
                report("min_limit", e.min_limit, got.min_limit);
            if (got.max_limit !== e.max_limit)
                report("max_limit", e.max_limit, got.max_limit);
            if (got.skipped !== e.skipped)
                report("skipped", e.skipped, got.skipped);
        endfunction

        function void report(input string f, input logic [62:0] e, input logic [62:0] a);
            $display("%0t: %s mismatch, expected %h actual %h", $time, f, e, a);
            errors++;
        endfunction
    endclass

    row_scoreboard rows;
    int cycles;
    int sent;
    int normals;
    int frictions;
    int skips;

    initial
    begin
        clk = 1'b0;
        rows = new();
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Check accepted rows and randomize the output stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                rows.check_row(out_ch.data);
            out_ch.ready <= pick_gap() == 0;
        end
    end

    int stall_mode;

    function automatic int pick_gap();
        int r;
        if (stall_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [62:0] rand_vec(input int mode);
        logic [62:0] v;
        v = 63'({$urandom, $urandom});
        if (mode == 1)
            for (int i = 0; i < 3; i++)
                v[i*21 +: 21] = 21'($signed($urandom_range(0, 16384)) - 8192);
        return v;
    endfunction

    function automatic in_item_t rand_row();
        in_item_t it;
        int mode;
        mode = $urandom_range(0, 3) == 0 ? 0 : 1;
        it.req_type = 1'($urandom_range(0, 1));
        it.contact_pos = rand_vec(mode);
        it.pos_a = rand_vec(mode);
        it.pos_b = rand_vec(mode);
        it.direction = rand_vec(mode);
        it.inv_mass_a = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 200000));
        it.inv_mass_b = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 200000));
        if ($urandom_range(0, 9) == 0)
            it.inv_mass_a = '0;
        it.penetration = $urandom_range(0, 2) == 0 ? $urandom
                                                   : 32'($signed($urandom_range(0, 70000)) - 2000);
        it.normal_lambda = $urandom;
        it.fric_mu = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 131072));
        it.has_normal_limit = $urandom_range(0, 3) != 0;
        it.bodies_present = $urandom_range(0, 7) != 0;
        return it;
    endfunction

    task automatic send_row(input in_item_t it);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        rows.note_row(it);
        sent++;
        if (it.req_type)
            frictions++;
        else if (!it.bodies_present)
            skips++;
        else
            normals++;
    endtask

    task automatic pause_send();
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Wait until every row is back and the pipe is empty, idle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (rows.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register, then drop the write enable and idle so writes never overlap
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TIME_STEP: dt_reg = val;
            CFG_BAUMGARTE: beta_reg = val[15:0];
            default: slop_reg = val;
        endcase
        @(posedge clk);
    endtask

    task automatic directed_rows();
        in_item_t it;
        it = '0;
        it.bodies_present = 1'b1;
        // Extremes of vectors, normal row
        it.contact_pos = {3{21'h0fffff}};
        it.pos_a = {3{21'h100000}};
        it.pos_b = {3{21'h100000}};
        it.direction = {3{21'h100000}};
        it.direction[0 +: 21] = 21'h0fffff;
        it.inv_mass_a = 31'h7fffffff;
        it.inv_mass_b = 31'h7fffffff;
        it.penetration = 32'sh7fffffff;
        send_row(it);
        // Zero mass sum and penetration below slop
        it = '0;
        it.bodies_present = 1'b1;
        it.penetration = 32'sh80000000;
        it.direction = {21'd4096, 21'd0, 21'd0};
        it.contact_pos = {21'd0, 21'd4096, 21'd0};
        send_row(it);
        // Tiny mass sum saturates the effective mass
        it.inv_mass_b = 31'd1;
        it.penetration = 32'sd329;
        send_row(it);
        // Skipped normal row
        it.bodies_present = 1'b0;
        send_row(it);
        // Linked friction, both lambda signs and extremes
        it = '0;
        it.req_type = 1'b1;
        it.has_normal_limit = 1'b1;
        it.fric_mu = 31'h7fffffff;
        it.normal_lambda = 32'sh7fffffff;
        it.inv_mass_a = 31'd65536;
        send_row(it);
        it.normal_lambda = 32'sh80000000;
        send_row(it);
        it.fric_mu = 31'd32768;
        it.normal_lambda = -32'sd3;
        send_row(it);
        // Unlinked friction ignores missing bodies
        it.has_normal_limit = 1'b0;
        it.bodies_present = 1'b0;
        send_row(it);
        for (int i = 0; i < 8; i++)
            send_row(rand_row());
    endtask

    task automatic random_rows(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ((i % 100) < 70)
                pause_send();
            send_row(rand_row());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TIME_STEP;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cycles = 0;
        stall_mode = 1;
        dt_reg = TIME_STEP_RST;
        beta_reg = BAUMGARTE_RST;
        slop_reg = SLOP_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults first, then register extremes, unit values and random values
        directed_rows();
        random_rows(200);
        drain();
        write_reg(CFG_TIME_STEP, 31'd0);
        write_reg(CFG_BAUMGARTE, 31'h0ffff);
        write_reg(CFG_SLOP, 31'd0);
        directed_rows();
        random_rows(120);
        drain();
        write_reg(CFG_TIME_STEP, 31'h7fffffff);
        write_reg(CFG_SLOP, 31'h7fffffff);
        write_reg(CFG_BAUMGARTE, 31'd0);
        random_rows(100);
        drain();
        write_reg(CFG_TIME_STEP, 31'd1);
        write_reg(CFG_BAUMGARTE, 31'd1);
        write_reg(CFG_SLOP, 31'd1);
        stall_mode = 0;
        random_rows(150);
        stall_mode = 1;
        drain();
        write_reg(CFG_TIME_STEP, 31'($urandom_range(1, 5000)));
        write_reg(CFG_BAUMGARTE, 31'($urandom_range(0, 65535)));
        write_reg(CFG_SLOP, 31'($urandom_range(0, 2000)));
        random_rows(230);
        drain();

        $display("covered %0d rows: %0d normal, %0d friction, %0d skipped, %0d checked",
                 sent, normals, frictions, skips, rows.checked);
        $display("register sets: defaults, zero step, max step and slop, unit values, random");
        if (rows.errors == 0 && rows.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
